/* hdl/mcwp_pkg.sv */
// ----------------------------------------------------------------------------
// mcwp_pkg
// Shared types and constants for the mapped character word packer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcwp_pkg;

	localparam int MAP_ENTRIES     = 256;
	localparam int MAP_IDX_W       = $clog2(MAP_ENTRIES);
	localparam int BYTE_W          = 8;
	localparam int CODE_W          = 8;
	localparam int WORD_BITS       = 32;
	localparam int SHIFT_W         = $clog2(WORD_BITS);
	localparam int COUNT_W         = 4;
	localparam int ALPHA_W         = 9;
	localparam int SMALL_CODE_BITS = 4;
	localparam int LARGE_CODE_BITS = 8;
	localparam int SMALL_ALPHABET  = 16;
	localparam int SMALL_CAPACITY  = WORD_BITS / SMALL_CODE_BITS;
	localparam int LARGE_CAPACITY  = WORD_BITS / LARGE_CODE_BITS;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(4);

	typedef enum logic {
		OP_MAP_WRITE = 1'b0,
		OP_PACK      = 1'b1
	} opcode_t;

endpackage

`default_nettype wire

/* hdl/mcwp_if.sv */
// ----------------------------------------------------------------------------
// mcwp_byte_if / mcwp_word_if
// Valid/ready channels: incoming bytes and map writes, outgoing packed words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcwp_byte_if;
	import mcwp_pkg::*;

	logic                valid;
	logic                ready;
	logic                opcode;
	logic [BYTE_W-1:0]   char_byte;
	logic [CODE_W-1:0]   map_value;
	logic                last;

	modport source (output valid, output opcode, output char_byte, output map_value,
		output last, input ready);
	modport sink (input valid, input opcode, input char_byte, input map_value,
		input last, output ready);
endinterface

interface mcwp_word_if;
	import mcwp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] packed_word;
	logic [COUNT_W-1:0]   char_count;
	logic                 last_word;

	modport source (output valid, output packed_word, output char_count,
		output last_word, input ready);
	modport sink (input valid, input packed_word, input char_count,
		input last_word, output ready);
endinterface

`default_nettype wire

/* hdl/mapped_char_word_packer.sv */
// ----------------------------------------------------------------------------
// mapped_char_word_packer
// Maps text bytes through a character table and packs the codes into words.
// ----------------------------------------------------------------------------
// A map write goes into the 256-entry table at its accept edge; a text byte
// reads the table at its accept edge into the read register, is packed from
// there into the accumulator, and a completed word leaves through the output
// register. The single table port and the one-slot accumulator set the rate of
// one input item per cycle while nothing stalls. A stalled word output holds
// the packing stage, which then holds the input.
`default_nettype none

module mapped_char_word_packer (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_wr_en,
	input  wire [mcwp_pkg::ALPHA_W-1:0]     cfg_wr_data,
	mcwp_byte_if.sink                       text,
	mcwp_word_if.source                     word
);
	import mcwp_pkg::*;

	logic [CODE_W-1:0]    char_map [MAP_ENTRIES];

	logic [ALPHA_W-1:0]   alpha_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [COUNT_W-1:0]   fill_q;

	logic                 valid_s1;
	logic                 last_s1;
	logic [CODE_W-1:0]    rdata_s1;

	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_word_q;
	logic [COUNT_W-1:0]   out_count_q;
	logic                 out_last_q;

	logic                 accept;
	logic                 map_wr;
	logic                 map_rd;
	logic [MAP_IDX_W-1:0] map_idx;

	logic                 small_mode;
	logic [CODE_W-1:0]    code;
	logic [SHIFT_W-1:0]   shift;
	logic [WORD_BITS-1:0] acc_next;
	logic [COUNT_W-1:0]   fill_next;
	logic [COUNT_W-1:0]   capacity;
	logic                 emit;
	logic                 s1_go;

	assign accept  = text.valid && text.ready;
	assign map_idx = text.char_byte[MAP_IDX_W-1:0];
	assign map_wr  = accept && (opcode_t'(text.opcode) == OP_MAP_WRITE);
	assign map_rd  = accept && (opcode_t'(text.opcode) == OP_PACK);

	always_ff @(posedge clk) begin
		if (map_wr) begin
			char_map[map_idx] <= text.map_value;
		end
		if (map_rd) begin
			rdata_s1 <= char_map[map_idx];
			last_s1  <= text.last;
		end
	end

	always_comb begin
		small_mode = (alpha_q <= ALPHA_W'(SMALL_ALPHABET));
		code       = ({1'b0, rdata_s1} >= alpha_q) ? '0 : rdata_s1;
		fill_next  = fill_q + COUNT_W'(1);
		if (small_mode) begin
			shift    = SHIFT_W'(WORD_BITS - (32'(fill_q) + 1) * SMALL_CODE_BITS);
			capacity = COUNT_W'(SMALL_CAPACITY);
		end else begin
			shift    = SHIFT_W'(WORD_BITS - (32'(fill_q) + 1) * LARGE_CODE_BITS);
			capacity = COUNT_W'(LARGE_CAPACITY);
		end
		acc_next = acc_q | (WORD_BITS'(code) << shift);
		emit     = (fill_next >= capacity) || last_s1;
		s1_go    = !(valid_s1 && emit && out_valid_q && !word.ready);
	end

	assign text.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= ALPHA_RESET;
			acc_q       <= '0;
			fill_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (text.ready) begin
				valid_s1 <= map_rd;
			end

			if (!cfg_wr_en && valid_s1 && s1_go && emit) begin
				out_valid_q <= 1'b1;
			end else if (word.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr_en) begin
				alpha_q <= cfg_wr_data;
				acc_q   <= '0;
				fill_q  <= '0;
			end else if (valid_s1 && s1_go) begin
				if (emit) begin
					acc_q  <= '0;
					fill_q <= '0;
				end else begin
					acc_q  <= acc_next;
					fill_q <= fill_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_go && emit) begin
			out_word_q  <= acc_next;
			out_count_q <= fill_next;
			out_last_q  <= last_s1;
		end
	end

	assign word.valid       = out_valid_q;
	assign word.packed_word = out_word_q;
	assign word.char_count  = out_count_q;
	assign word.last_word   = out_last_q;

`ifndef SYNTHESIS
	a_fill_below_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < capacity)
		else $error("accumulator reached capacity without emitting");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && emit && out_valid_q && !word.ready |=> valid_s1 && $stable(acc_q))
		else $error("packing stage lost a byte while output stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		word.valid |-> word.char_count != '0 && word.char_count <= capacity)
		else $error("word count out of range");
`endif

endmodule

`default_nettype wire
